/* rtl/core/hsv_to_rgb_converter_defines.svh */
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define HSV2RGB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define HSV2RGB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HSV2RGB_ASSERT(label, clk, rst_n, prop, msg)
`define HSV2RGB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/core/hsv2rgb_pkg.sv */
// Shared types for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int SECTOR_BITS = 3;

    // Hue sectors of the color circle, one per sixth.
    typedef enum logic [SECTOR_BITS-1:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } sector_t;

endpackage

/* rtl/core/hsv2rgb_hsv_if.sv */
// Valid/ready channel carrying one HSV pixel.
interface hsv2rgb_hsv_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] hue;
    logic [W-1:0] saturation;
    logic [W-1:0] brightness;

    modport source (
        output valid,
        output hue,
        output saturation,
        output brightness,
        input  ready
    );

    modport sink (
        input  valid,
        input  hue,
        input  saturation,
        input  brightness,
        output ready
    );
endinterface

/* rtl/core/hsv2rgb_rgb_if.sv */
// Valid/ready channel carrying one RGB pixel.
interface hsv2rgb_rgb_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;

    modport source (
        output valid,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  red,
        input  green,
        input  blue,
        output ready
    );
endinterface

/* rtl/core/hsv_to_rgb_converter.sv */
// Top level of the pipelined HSV to RGB pixel converter.
//
// Usage:
//   Pixels enter on the hsv channel (hue, saturation, brightness) and leave
//   on the rgb channel (red, green, blue), one result per pixel, in order.
//   Both channels use valid/ready; a transfer happens on a rising clock edge
//   with valid and ready both high.
//   The datapath has four register stages: sector split and saturation
//   products, brightness products, division by the channel maximum, and the
//   channel-order select in the output register.
//   Throughput is one pixel per clock while rgb is not stalled; the
//   multipliers in the first two stages set the clock period.
//   Each stage holds its pixel while the next stage is full and not moving,
//   so a stall on rgb backs up stage by stage and hsv.ready drops only when
//   all four stages are occupied. Empty stages are filled up during a stall.
//   Reset (rst_n low, asynchronous) empties the pipeline; there is no other
//   state and no configuration.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hsv2rgb_hsv_if.sink          hsv,
    hsv2rgb_rgb_if.source        rgb
);
    localparam int W = CHANNEL_BITS;

    localparam logic [W-1:0]   CH_MAX   = {W{1'b1}};
    localparam logic [W:0]     CH_ONE   = {1'b1, {W{1'b0}}};
    localparam logic [2*W-1:0] HALF_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [2*W-1:0] DEN      = {CH_MAX, {W{1'b0}}};
    localparam logic [3*W-1:0] HALF_DEN = {{(W+1){1'b0}}, CH_MAX, {(W-1){1'b0}}};

    // Stage handshake: a stage loads when it is empty or its content moves on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_load, s2_load, s3_load, s4_load;

    always_comb
    begin
        s4_load = !s4_valid_reg || rgb.ready;
        s3_load = !s3_valid_reg || s4_load;
        s2_load = !s2_valid_reg || s3_load;
        s1_load = !s1_valid_reg || s2_load;
    end

    assign hsv.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= hsv.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_load)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: hue * 6 splits into sector and fraction; saturation products.
    logic [W+2:0]              hue6;
    logic [W:0]                frac_rest;
    logic [2*W:0]              sat_rest_wide;
    hsv2rgb_pkg::sector_t      s1_sector_next;
    logic [2*W-1:0]            s1_sat_frac_next;
    logic [2*W-1:0]            s1_sat_rest_next;

    hsv2rgb_pkg::sector_t      s1_sector_reg;
    logic [W-1:0]              s1_sat_reg;
    logic [W-1:0]              s1_val_reg;
    logic [2*W-1:0]            s1_sat_frac_reg;
    logic [2*W-1:0]            s1_sat_rest_reg;
    logic                      s1_grey_reg;

    always_comb
    begin
        hue6             = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
        s1_sector_next   = hsv2rgb_pkg::sector_t'(hue6[W+2:W]);
        frac_rest        = CH_ONE - {1'b0, hue6[W-1:0]};
        s1_sat_frac_next = {{W{1'b0}}, hsv.saturation} * {{W{1'b0}}, hue6[W-1:0]};
        sat_rest_wide    = {{(W+1){1'b0}}, hsv.saturation} * {{W{1'b0}}, frac_rest};
        s1_sat_rest_next = sat_rest_wide[2*W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_sector_reg   <= s1_sector_next;
            s1_sat_reg      <= hsv.saturation;
            s1_val_reg      <= hsv.brightness;
            s1_sat_frac_reg <= s1_sat_frac_next;
            s1_sat_rest_reg <= s1_sat_rest_next;
            s1_grey_reg     <= (hsv.saturation == '0);
        end
    end

    // Stage 2: brightness times each factor, plus half the divisor for rounding.
    logic [W-1:0]              p_factor;
    logic [2*W-1:0]            q_factor;
    logic [2*W-1:0]            t_factor;
    logic [2*W-1:0]            s2_p_num_next;
    logic [3*W-1:0]            s2_q_num_next;
    logic [3*W-1:0]            s2_t_num_next;

    hsv2rgb_pkg::sector_t      s2_sector_reg;
    logic [W-1:0]              s2_val_reg;
    logic [2*W-1:0]            s2_p_num_reg;
    logic [3*W-1:0]            s2_q_num_reg;
    logic [3*W-1:0]            s2_t_num_reg;
    logic                      s2_grey_reg;

    always_comb
    begin
        p_factor      = CH_MAX - s1_sat_reg;
        q_factor      = DEN - s1_sat_frac_reg;
        t_factor      = DEN - s1_sat_rest_reg;
        s2_p_num_next = ({{W{1'b0}}, s1_val_reg} * {{W{1'b0}}, p_factor}) + HALF_MAX;
        s2_q_num_next = ({{(2*W){1'b0}}, s1_val_reg} * {{W{1'b0}}, q_factor}) + HALF_DEN;
        s2_t_num_next = ({{(2*W){1'b0}}, s1_val_reg} * {{W{1'b0}}, t_factor}) + HALF_DEN;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
            s2_p_num_reg  <= s2_p_num_next;
            s2_q_num_reg  <= s2_q_num_next;
            s2_t_num_reg  <= s2_t_num_next;
            s2_grey_reg   <= s1_grey_reg;
        end
    end

    // Stage 3: divide by the channel maximum. The q and t divisors carry an
    // extra factor 2^W, which is dropped first as a plain shift.
    logic [W-1:0]              s3_p_next;
    logic [W-1:0]              s3_q_next;
    logic [W-1:0]              s3_t_next;

    hsv2rgb_pkg::sector_t      s3_sector_reg;
    logic [W-1:0]              s3_val_reg;
    logic [W-1:0]              s3_p_reg;
    logic [W-1:0]              s3_q_reg;
    logic [W-1:0]              s3_t_reg;
    logic                      s3_grey_reg;

    hsv2rgb_div_max #(.W(W)) u_div_p (
        .num (s2_p_num_reg),
        .quo (s3_p_next)
    );

    hsv2rgb_div_max #(.W(W)) u_div_q (
        .num (s2_q_num_reg[3*W-1:W]),
        .quo (s3_q_next)
    );

    hsv2rgb_div_max #(.W(W)) u_div_t (
        .num (s2_t_num_reg[3*W-1:W]),
        .quo (s3_t_next)
    );

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_p_reg      <= s3_p_next;
            s3_q_reg      <= s3_q_next;
            s3_t_reg      <= s3_t_next;
            s3_grey_reg   <= s2_grey_reg;
        end
    end

    // Stage 4: the sector picks the channel order into the output register.
    logic [W-1:0] red_next, green_next, blue_next;
    logic [W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        case (s3_sector_reg)
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                red_next   = s3_q_reg;
                green_next = s3_val_reg;
                blue_next  = s3_p_reg;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                red_next   = s3_p_reg;
                green_next = s3_val_reg;
                blue_next  = s3_t_reg;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                red_next   = s3_p_reg;
                green_next = s3_q_reg;
                blue_next  = s3_val_reg;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next   = s3_t_reg;
                green_next = s3_p_reg;
                blue_next  = s3_val_reg;
            end
            hsv2rgb_pkg::SEC_MAGENTA_RED:
            begin
                red_next   = s3_val_reg;
                green_next = s3_p_reg;
                blue_next  = s3_q_reg;
            end
            default:
            begin
                red_next   = s3_val_reg;
                green_next = s3_t_reg;
                blue_next  = s3_p_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = s4_valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

    // Zero saturation must come out of the dividers as plain brightness.
    `HSV2RGB_ASSERT(a_grey_exact, clk, rst_n,
        (s3_valid_reg && s3_grey_reg |-> (s3_p_reg == s3_val_reg &&
            s3_q_reg == s3_val_reg && s3_t_reg == s3_val_reg)),
        "grey pixel not equal to brightness")

    // The rounded p, q and t keep the order p <= q, t <= v.
    `HSV2RGB_ASSERT(a_channel_order, clk, rst_n,
        (s3_valid_reg |-> (s3_p_reg <= s3_q_reg && s3_p_reg <= s3_t_reg &&
            s3_q_reg <= s3_val_reg && s3_t_reg <= s3_val_reg)),
        "p, q, t out of order")

    // Input back-pressure appears only when every stage holds a pixel.
    `HSV2RGB_ASSERT(a_ready_full, clk, rst_n,
        (!hsv.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg &&
            s4_valid_reg && !rgb.ready)),
        "input stalled with room in the pipeline")

endmodule

/* rtl/core/hsv2rgb_div_max.sv */
// Floor division of a 2W-bit value by the channel maximum 2^W - 1.
module hsv2rgb_div_max #(
    parameter int W = 8
) (
    input  logic [2*W-1:0] num,
    output logic [W-1:0]   quo
);
    localparam logic [W:0] MAX_EXT = {1'b0, {W{1'b1}}};
    localparam logic [W:0] TWO_MAX = {{W{1'b1}}, 1'b0};

    logic [W-1:0] q_est;
    logic [W:0]   rem;
    logic [W:0]   quo_wide;

    // num = q_est * 2^W + low = q_est * (2^W - 1) + (q_est + low), and the
    // remainder estimate never exceeds twice the divisor.
    always_comb
    begin
        q_est    = num[2*W-1:W];
        rem      = {1'b0, num[W-1:0]} + {1'b0, q_est};
        quo_wide = {1'b0, q_est}
                 + {{W{1'b0}}, (rem >= MAX_EXT)}
                 + {{W{1'b0}}, (rem >= TWO_MAX)};
        quo      = quo_wide[W-1:0];
    end
endmodule

/* verif/tb_hsv_to_rgb_converter.sv */
// Self-checking testbench for the HSV to RGB pixel converter.
module tb_hsv_to_rgb_converter;

    localparam int CB = 8;
    localparam int CH_MAX = (1 << CB) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PIXELS = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } rgb_pixel_t;

    // Holds the predicted colors of accepted pixels in arrival order.
    class pixel_scoreboard;
        rgb_pixel_t expected_rgb[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function rgb_pixel_t hsv_to_rgb(logic [CB-1:0] h, logic [CB-1:0] s, logic [CB-1:0] v);
            int unsigned hi, si, vi, h6, fr, den, p, q, t;
            hsv2rgb_pkg::sector_t sec;
            rgb_pixel_t px;
            hi = h;
            si = s;
            vi = v;
            if (si == 0) begin
                px = '{red: v, green: v, blue: v};
                return px;
            end
            h6 = hi * 6;
            sec = hsv2rgb_pkg::sector_t'(3'(h6 >> CB));
            fr = h6 & CH_MAX;
            den = CH_MAX * (CH_MAX + 1);
            // Each term is rounded to nearest with ties going up.
            p = (vi * (CH_MAX - si) + CH_MAX / 2) / CH_MAX;
            q = (vi * (den - si * fr) + den / 2) / den;
            t = (vi * (den - si * (CH_MAX + 1 - fr)) + den / 2) / den;
            case (sec)
                hsv2rgb_pkg::SEC_YELLOW_GREEN:
                    px = '{red: q[CB-1:0], green: v, blue: p[CB-1:0]};
                hsv2rgb_pkg::SEC_GREEN_CYAN:
                    px = '{red: p[CB-1:0], green: v, blue: t[CB-1:0]};
                hsv2rgb_pkg::SEC_CYAN_BLUE:
                    px = '{red: p[CB-1:0], green: q[CB-1:0], blue: v};
                hsv2rgb_pkg::SEC_BLUE_MAGENTA:
                    px = '{red: t[CB-1:0], green: p[CB-1:0], blue: v};
                hsv2rgb_pkg::SEC_MAGENTA_RED:
                    px = '{red: v, green: p[CB-1:0], blue: q[CB-1:0]};
                default:
                    px = '{red: v, green: t[CB-1:0], blue: p[CB-1:0]};
            endcase
            return px;
        endfunction

        function void note_pixel(logic [CB-1:0] h, logic [CB-1:0] s, logic [CB-1:0] v);
            expected_rgb.push_back(hsv_to_rgb(h, s, v));
        endfunction

        function void check_pixel(rgb_pixel_t got);
            rgb_pixel_t want;
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected rgb transfer r=%0d g=%0d b=%0d",
                         $time, got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red mismatch, expected %0d, got %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green mismatch, expected %0d, got %0d",
                         $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue mismatch, expected %0d, got %0d",
                         $time, want.blue, got.blue);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hsv2rgb_hsv_if #(.W(CB)) hsv_ch ();
    hsv2rgb_rgb_if #(.W(CB)) rgb_ch ();

    hsv_to_rgb_converter #(
        .CHANNEL_BITS(CB)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .hsv  (hsv_ch),
        .rgb  (rgb_ch)
    );

    pixel_scoreboard sb = new();

    int cycle_count = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    bit long_hold_req = 0;

    // Directed pixels as {hue, saturation, brightness}.
    logic [3*CB-1:0] directed_hsv[20] = '{
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255},
        {8'd0,   8'd255, 8'd255},
        {8'd42,  8'd255, 8'd255},
        {8'd43,  8'd255, 8'd255},
        {8'd85,  8'd200, 8'd255},
        {8'd86,  8'd255, 8'd128},
        {8'd128, 8'd255, 8'd255},
        {8'd170, 8'd128, 8'd255},
        {8'd171, 8'd255, 8'd200},
        {8'd213, 8'd255, 8'd255},
        {8'd214, 8'd100, 8'd255},
        {8'd255, 8'd1,   8'd255},
        {8'd100, 8'd0,   8'd200},
        {8'd255, 8'd0,   8'd255},
        {8'd77,  8'd200, 8'd0},
        {8'd1,   8'd255, 8'd1},
        {8'd127, 8'd254, 8'd254},
        {8'd192, 8'd170, 8'd85},
        {8'd64,  8'd85,  8'd170}
    };

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly random pauses, with occasional stretches of none at all.
    function int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    task send_pixel(input logic [CB-1:0] h, input logic [CB-1:0] s,
                    input logic [CB-1:0] v, input int gap);
        if (gap > 0) begin
            hsv_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= h;
        hsv_ch.saturation <= s;
        hsv_ch.brightness <= v;
        do @(posedge clk); while (!hsv_ch.ready);
    endtask

    // Receiver: random stalls per pixel, plus one long hold on request.
    initial begin
        int stall;
        rgb_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                rgb_ch.ready <= 1'b0;
                repeat (80) @(posedge clk);
            end else begin
                stall = draw_pause(rx_calm);
                if (stall > 0) begin
                    rgb_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rgb_ch.ready <= 1'b1;
            do @(posedge clk); while (!rgb_ch.valid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
            sb.note_pixel(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
            sb.check_pixel('{red: rgb_ch.red, green: rgb_ch.green, blue: rgb_ch.blue});
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [CB-1:0] h, s, v;
        int burst;
        int mode;
        burst = 0;
        rst_n             <= 1'b0;
        hsv_ch.valid      <= 1'b0;
        hsv_ch.hue        <= '0;
        hsv_ch.saturation <= '0;
        hsv_ch.brightness <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_hsv[i])
            send_pixel(directed_hsv[i][3*CB-1:2*CB], directed_hsv[i][2*CB-1:CB],
                       directed_hsv[i][CB-1:0], draw_pause(tx_calm));

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            // Back-to-back pixels against a long output stall fill the pipeline.
            if (i == 150) begin
                long_hold_req = 1;
                burst = 30;
            end
            mode = $urandom_range(0, 9);
            h = CB'($urandom_range(0, CH_MAX));
            s = (mode == 0) ? 8'd0 : (mode == 2) ? 8'(CH_MAX) : 8'($urandom_range(0, CH_MAX));
            v = (mode == 1) ? ($urandom_range(0, 1) ? 8'(CH_MAX) : 8'd0)
                            : 8'($urandom_range(0, CH_MAX));
            if (burst > 0) begin
                burst--;
                send_pixel(h, s, v, 0);
            end else begin
                send_pixel(h, s, v, draw_pause(tx_calm));
            end
        end
        hsv_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
